@@ hw/rtl/cfrj_pkg.sv @@
// Package: shared constants and types for the cylinder fit residual/Jacobian block.
package cfrj_pkg;
    localparam int FRAC_BITS = 16;
    localparam logic signed [31:0] ONE_FX = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [63:0] HALF_LSB = 64'sd1 <<< (FRAC_BITS - 1);
    localparam logic [2:0] REG_PX = 3'd0;
    localparam logic [2:0] REG_PY = 3'd1;
    localparam logic [2:0] REG_PZ = 3'd2;
    localparam logic [2:0] REG_DA = 3'd3;
    localparam logic [2:0] REG_DB = 3'd4;
    localparam logic [2:0] REG_DC = 3'd5;
    localparam logic [2:0] REG_RAD = 3'd6;
    localparam logic [2:0] REG_LIM = 3'd7;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic               last_point;
    } t_in;

    typedef struct packed {
        logic signed [31:0] residual;
        logic signed [31:0] d_axis_x;
        logic signed [31:0] d_axis_y;
        logic signed [31:0] d_axis_z;
        logic signed [31:0] d_dir_a;
        logic signed [31:0] d_dir_b;
        logic signed [31:0] d_dir_c;
        logic               last_result;
    } t_out;

    function automatic logic signed [31:0] sat32(input logic signed [127:0] v);
        if (v > 128'sd2147483647) return 32'sh7fffffff;
        if (v < -128'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction
endpackage

@@ hw/rtl/cfrj_if.sv @@
// Interfaces: valid/ready channels for point and result words.
interface cfrj_in_if import cfrj_pkg::*; ();
    logic valid;
    logic ready;
    t_in  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface cfrj_out_if import cfrj_pkg::*; ();
    logic valid;
    logic ready;
    t_out data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/cfrj_isqrt.sv @@
// Pipelined integer square root, two result bits per stage, floor result.
module cfrj_isqrt import cfrj_pkg::*; (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [63:0]  i_v,
    output logic [31:0]  o_root
);
    localparam int STG = 16;
    logic [63:0] r_rem [STG];
    logic [31:0] r_res [STG];
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < STG; s++) begin
                logic [63:0] rem;
                logic [31:0] res;
                logic [65:0] trial;
                rem = (s == 0) ? i_v : r_rem[s-1];
                res = (s == 0) ? 32'd0 : r_res[s-1];
                for (int k = 0; k < 2; k++) begin
                    trial = {res, 2'b01} << (62 - 2 * (2 * s + k));
                    if ({2'd0, rem} >= trial) begin
                        rem = rem - trial[63:0];
                        res = {res[30:0], 1'b1};
                    end else begin
                        res = {res[30:0], 1'b0};
                    end
                end
                r_rem[s] <= rem;
                r_res[s] <= res;
            end
        end
    end
    assign o_root = r_res[STG-1];
endmodule

@@ hw/rtl/cfrj_div.sv @@
// Pipelined signed divider: 64-bit numerator by 32-bit positive divisor, truncating, saturated.
module cfrj_div import cfrj_pkg::*; (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [63:0] i_num,
    input  logic [31:0]        i_den,
    output logic signed [31:0] o_q
);
    localparam int STG = 16;
    logic [63:0] r_q   [STG];
    logic [32:0] r_rem [STG];
    logic [63:0] r_n   [STG];
    logic [31:0] r_d   [STG];
    logic        r_neg [STG];
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < STG; s++) begin
                logic [63:0] n, q;
                logic [32:0] rem;
                logic [31:0] d;
                logic        ng;
                if (s == 0) begin
                    ng = i_num[63];
                    n = ng ? 64'(-i_num) : i_num;
                    q = 64'd0;
                    rem = 33'd0;
                    d = i_den;
                end else begin
                    n = r_n[s-1]; q = r_q[s-1]; rem = r_rem[s-1];
                    d = r_d[s-1]; ng = r_neg[s-1];
                end
                for (int k = 0; k < 4; k++) begin
                    rem = {rem[31:0], n[63]};
                    n = {n[62:0], 1'b0};
                    if (rem >= {1'b0, d}) begin
                        rem = rem - {1'b0, d};
                        q = {q[62:0], 1'b1};
                    end else begin
                        q = {q[62:0], 1'b0};
                    end
                end
                r_n[s] <= n; r_q[s] <= q; r_rem[s] <= rem;
                r_d[s] <= d; r_neg[s] <= ng;
            end
        end
    end
    always_comb begin
        logic signed [65:0] sq;
        sq = r_neg[STG-1] ? -$signed({2'b00, r_q[STG-1]}) : $signed({2'b00, r_q[STG-1]});
        o_q = sat32(128'(sq));
    end
endmodule

@@ hw/rtl/cylinder_fit_residual_jacobian.sv @@
// Top level: cylinder fit residual and Jacobian pipeline.
// One point word per cycle within a set while no result word stalls. The
// depth is set by the 16-stage pipelined square root for the axis distance
// and the 16-stage pipelined dividers for the derivatives, plus five stages
// in front, the r_f/r_nx registers between the two and three behind.
// A stalled result word freezes the whole pipeline, input included. The axis
// direction is normalized when a set starts: the first point of a set is held
// at the input while the normalization counter runs down, which pauses while
// the result side stalls, so that points still in flight from the previous set keep the old direction.
module cylinder_fit_residual_jacobian import cfrj_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    cfrj_in_if.sink     s_in,
    cfrj_out_if.source  m_out
);
    localparam int NL = 40;
    localparam int L = 41;

    logic signed [31:0] r_px, r_py, r_pz, r_da, r_db, r_dc;
    logic [30:0] r_rad;
    logic [16:0] r_lim;
    logic signed [31:0] r_ua, r_ub, r_uc;
    logic r_active, r_norm_busy;
    logic [6:0] r_ncnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_px <= '0; r_py <= '0; r_pz <= '0;
            r_da <= '0; r_db <= ONE_FX; r_dc <= '0;
            r_rad <= 31'(ONE_FX); r_lim <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_PX:  r_px <= i_cfg_data;
                REG_PY:  r_py <= i_cfg_data;
                REG_PZ:  r_pz <= i_cfg_data;
                REG_DA:  r_da <= i_cfg_data;
                REG_DB:  r_db <= i_cfg_data;
                REG_DC:  r_dc <= i_cfg_data;
                REG_RAD: r_rad <= i_cfg_data[30:0];
                REG_LIM: r_lim <= i_cfg_data[16:0];
                default: ;
            endcase
        end
    end

    // normalization: norm^2 -> isqrt -> three divides, in their own pipes
    logic [63:0] nrm2;
    logic [31:0] nrm;
    logic signed [31:0] qa, qb, qc;
    always_comb begin
        logic [63:0] a2, b2, c2;
        a2 = 64'($signed(r_da) * $signed(r_da));
        b2 = 64'($signed(r_db) * $signed(r_db));
        c2 = 64'($signed(r_dc) * $signed(r_dc));
        nrm2 = a2 + b2 + c2;
    end
    logic [63:0] r_nrm2;
    always_ff @(posedge i_clk) r_nrm2 <= nrm2;
    cfrj_isqrt u_nsq (.i_clk, .i_en(1'b1), .i_v(r_nrm2), .o_root(nrm));
    cfrj_div u_na (.i_clk, .i_en(1'b1), .i_num(64'(r_da) <<< FRAC_BITS),
                   .i_den(nrm), .o_q(qa));
    cfrj_div u_nb (.i_clk, .i_en(1'b1), .i_num(64'(r_db) <<< FRAC_BITS),
                   .i_den(nrm), .o_q(qb));
    cfrj_div u_nc (.i_clk, .i_en(1'b1), .i_num(64'(r_dc) <<< FRAC_BITS),
                   .i_den(nrm), .o_q(qc));

    // main pipeline
    logic run;
    logic [L-1:0] r_v;
    t_in r_in [L-1];
    assign run = !r_v[L-1] || m_out.ready;
    assign s_in.ready = run && r_active;
    logic acc;
    assign acc = s_in.valid && s_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0; r_norm_busy <= 1'b0; r_ncnt <= '0;
            r_ua <= '0; r_ub <= ONE_FX; r_uc <= '0;
        end else if (!r_active && !r_norm_busy && s_in.valid) begin
            r_norm_busy <= 1'b1; r_ncnt <= 7'(NL);
        end else if (r_norm_busy) begin
            if (run) begin
                if (r_ncnt == 7'd0) begin
                    r_norm_busy <= 1'b0; r_active <= 1'b1;
                    r_ua <= nrm == 32'd0 ? 32'sd0 : qa;
                    r_ub <= nrm == 32'd0 ? 32'sd0 : qb;
                    r_uc <= nrm == 32'd0 ? 32'sd0 : qc;
                end else r_ncnt <= r_ncnt - 7'd1;
            end
        end else if (acc && s_in.data.last_point) r_active <= 1'b0;
    end

    // stage 0: differences
    logic signed [31:0] r_dx, r_dy, r_dz;
    // stage 1: products
    logic signed [63:0] r_pa, r_pb, r_pc;
    logic [63:0] r_sx, r_sy, r_sz;
    logic signed [31:0] r_dx1, r_dy1, r_dz1;
    // stage 2: g and d2
    logic signed [31:0] r_g;
    logic [63:0] r_d2;
    logic signed [31:0] r_dx2, r_dy2, r_dz2, r_g3;
    logic [63:0] r_d3, r_g2;
    logic signed [31:0] r_dx3, r_dy3, r_dz3;
    logic [63:0] r_farg;
    logic [31:0] f;
    logic signed [31:0] r_dxs [17];
    logic signed [31:0] r_dys [17];
    logic signed [31:0] r_dzs [17];
    logic signed [31:0] r_gs [18];
    logic [31:0] r_f;
    logic signed [63:0] r_nx, r_ny, r_nz;
    logic signed [31:0] jxn, jyn, jzn;
    logic [31:0] r_fs [16];
    logic signed [31:0] r_gq [16];
    logic signed [31:0] r_jx, r_jy, r_jz, r_gj;
    logic [31:0] r_fj, r_f2;
    logic signed [63:0] r_mx, r_my, r_mz;
    logic signed [31:0] r_jx2, r_jy2, r_jz2;
    t_out r_o;
    logic signed [31:0] dega, degb, degc;

    // degenerate values depend only on unit direction; hold as registers
    logic [31:0] r_dg_a, r_dg_b, r_dg_c;
    logic [63:0] r_ua2, r_ub2, r_uc2;
    always_ff @(posedge i_clk) begin
        r_ua2 <= 64'(r_ua * r_ua);
        r_ub2 <= 64'(r_ub * r_ub);
        r_uc2 <= 64'(r_uc * r_uc);
    end
    localparam logic [63:0] FULL = 64'd1 << (2 * FRAC_BITS);
    cfrj_isqrt u_dga (.i_clk, .i_en(1'b1),
        .i_v(r_ua2 >= FULL ? 64'd0 : FULL - r_ua2), .o_root(r_dg_a));
    cfrj_isqrt u_dgb (.i_clk, .i_en(1'b1),
        .i_v(r_ub2 >= FULL ? 64'd0 : FULL - r_ub2), .o_root(r_dg_b));
    cfrj_isqrt u_dgc (.i_clk, .i_en(1'b1),
        .i_v(r_uc2 >= FULL ? 64'd0 : FULL - r_uc2), .o_root(r_dg_c));
    assign dega = r_dg_a; assign degb = r_dg_b; assign degc = r_dg_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v <= '0;
        else if (run) r_v <= {r_v[L-2:0], acc};
    end
    always_ff @(posedge i_clk) begin
        if (run) begin
            r_in[0] <= s_in.data;
            for (int i = 1; i < L - 1; i++) r_in[i] <= r_in[i-1];
        end
    end

    cfrj_isqrt u_f (.i_clk, .i_en(run), .i_v(r_farg), .o_root(f));

    always_ff @(posedge i_clk) begin
        if (run) begin
            r_dx <= sat32(128'($signed(s_in.data.point_x)) - 128'(r_px));
            r_dy <= sat32(128'($signed(s_in.data.point_y)) - 128'(r_py));
            r_dz <= sat32(128'($signed(s_in.data.point_z)) - 128'(r_pz));
            r_pa <= r_dx * r_ua; r_pb <= r_dy * r_ub; r_pc <= r_dz * r_uc;
            r_sx <= 64'(r_dx * r_dx); r_sy <= 64'(r_dy * r_dy);
            r_sz <= 64'(r_dz * r_dz);
            r_dx1 <= r_dx; r_dy1 <= r_dy; r_dz1 <= r_dz;
            r_g <= sat32(128'((66'(r_pa) + 66'(r_pb) + 66'(r_pc)
                   + 66'(HALF_LSB)) >>> FRAC_BITS));
            r_d2 <= r_sx + r_sy + r_sz;
            r_dx2 <= r_dx1; r_dy2 <= r_dy1; r_dz2 <= r_dz1;
            r_g2 <= 64'(r_g * r_g); r_d3 <= r_d2; r_g3 <= r_g;
            r_dx3 <= r_dx2; r_dy3 <= r_dy2; r_dz3 <= r_dz2;
            r_farg <= r_d3 > r_g2 ? r_d3 - r_g2 : 64'd0;
            r_dxs[0] <= r_dx3; r_dys[0] <= r_dy3; r_dzs[0] <= r_dz3;
            r_gs[0] <= r_g3;
            for (int i = 1; i < 17; i++) begin
                r_dxs[i] <= r_dxs[i-1]; r_dys[i] <= r_dys[i-1];
                r_dzs[i] <= r_dzs[i-1];
            end
            for (int i = 1; i < 18; i++) r_gs[i] <= r_gs[i-1];
            r_f <= f;
            r_nx <= 64'(r_ua * r_gs[16]) - (64'(r_dxs[16]) <<< FRAC_BITS);
            r_ny <= 64'(r_ub * r_gs[16]) - (64'(r_dys[16]) <<< FRAC_BITS);
            r_nz <= 64'(r_uc * r_gs[16]) - (64'(r_dzs[16]) <<< FRAC_BITS);
            r_fs[0] <= r_f; r_gq[0] <= r_gs[17];
            for (int i = 1; i < 16; i++) begin
                r_fs[i] <= r_fs[i-1]; r_gq[i] <= r_gq[i-1];
            end
            if (r_fs[15] > {15'd0, r_lim}) begin
                r_jx <= jxn; r_jy <= jyn; r_jz <= jzn;
            end else begin
                r_jx <= dega; r_jy <= degb; r_jz <= degc;
            end
            r_gj <= r_gq[15]; r_fj <= r_fs[15];
            r_mx <= r_gj * r_jx; r_my <= r_gj * r_jy; r_mz <= r_gj * r_jz;
            r_jx2 <= r_jx; r_jy2 <= r_jy; r_jz2 <= r_jz; r_f2 <= r_fj;
            r_o.residual <= sat32(128'(r_f2) - 128'({1'b0, r_rad}));
            r_o.d_axis_x <= r_jx2; r_o.d_axis_y <= r_jy2; r_o.d_axis_z <= r_jz2;
            r_o.d_dir_a <= sat32(128'((r_mx + HALF_LSB) >>> FRAC_BITS));
            r_o.d_dir_b <= sat32(128'((r_my + HALF_LSB) >>> FRAC_BITS));
            r_o.d_dir_c <= sat32(128'((r_mz + HALF_LSB) >>> FRAC_BITS));
            r_o.last_result <= r_in[L-2].last_point;
        end
    end

    cfrj_div u_jx (.i_clk, .i_en(run), .i_num(r_nx), .i_den(r_f), .o_q(jxn));
    cfrj_div u_jy (.i_clk, .i_en(run), .i_num(r_ny), .i_den(r_f), .o_q(jyn));
    cfrj_div u_jz (.i_clk, .i_en(run), .i_num(r_nz), .i_den(r_f), .o_q(jzn));

    assign m_out.valid = r_v[L-1];
    assign m_out.data = r_o;
endmodule

@@ tb/cylinder_fit_residual_jacobian_test.sv @@
// Testbench: self-checking stimulus and residual/Jacobian prediction for the cylinder fit block.
`timescale 1ns / 100ps

module cylinder_fit_residual_jacobian_test import cfrj_pkg::*; ();

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES = 200;
    localparam int HOLD_CYCLES = 400;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;

    cfrj_in_if  pts ();
    cfrj_out_if res ();

    cylinder_fit_residual_jacobian u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .s_in       (pts),
        .m_out      (res)
    );

    longint axis_x, axis_y, axis_z, dir_a, dir_b, dir_c, radius, limit;
    longint unit_a, unit_b, unit_c;
    bit     set_open;

    t_out   expected_results[$];
    int     error_count;
    bit     no_idle;
    bit     hold_req;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic longint sat(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint rshift_round(longint x);
        return (x + 64'sd32768) >>> FRAC_BITS;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned probe;
        root = 0;
        probe = 64'd1 << 62;
        while (probe > v) probe = probe >> 2;
        while (probe != 0) begin
            if (v >= root + probe) begin
                v = v - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root;
    endfunction

    function automatic longint unsigned square(longint v);
        longint unsigned m;
        m = (v < 0) ? -v : v;
        return m * m;
    endfunction

    function automatic longint grad_normal(longint u, longint g, longint d, longint f);
        return sat((u * g - d * 64'sd65536) / f);
    endfunction

    function automatic longint grad_degenerate(longint u);
        longint unsigned full;
        longint unsigned u2;
        full = 64'd1 << (2 * FRAC_BITS);
        u2 = square(u);
        return sat(longint'(int_sqrt(u2 >= full ? 64'd0 : full - u2)));
    endfunction

    function automatic void reset_model();
        axis_x = 0; axis_y = 0; axis_z = 0;
        dir_a = 0; dir_b = 65536; dir_c = 0;
        radius = 65536; limit = 0;
        unit_a = 0; unit_b = 65536; unit_c = 0;
        set_open = 0;
    endfunction

    function automatic t_out fit_point(t_in p);
        longint unsigned n2, d2, g2;
        longint norm, dx, dy, dz, g, f, jx, jy, jz;
        t_out r;
        if (!set_open) begin
            n2 = square(dir_a) + square(dir_b) + square(dir_c);
            norm = longint'(int_sqrt(n2));
            if (norm == 0) begin
                unit_a = 0; unit_b = 0; unit_c = 0;
            end else begin
                unit_a = sat((dir_a * 64'sd65536) / norm);
                unit_b = sat((dir_b * 64'sd65536) / norm);
                unit_c = sat((dir_c * 64'sd65536) / norm);
            end
            set_open = 1;
        end
        dx = sat(longint'(p.point_x) - axis_x);
        dy = sat(longint'(p.point_y) - axis_y);
        dz = sat(longint'(p.point_z) - axis_z);
        g = sat(rshift_round(dx * unit_a + dy * unit_b + dz * unit_c));
        d2 = square(dx) + square(dy) + square(dz);
        g2 = square(g);
        f = longint'(int_sqrt(d2 > g2 ? d2 - g2 : 64'd0));
        if (f > limit) begin
            jx = grad_normal(unit_a, g, dx, f);
            jy = grad_normal(unit_b, g, dy, f);
            jz = grad_normal(unit_c, g, dz, f);
        end else begin
            jx = grad_degenerate(unit_a);
            jy = grad_degenerate(unit_b);
            jz = grad_degenerate(unit_c);
        end
        r.residual = sat(f - radius);
        r.d_axis_x = jx;
        r.d_axis_y = jy;
        r.d_axis_z = jz;
        r.d_dir_a = sat(rshift_round(g * jx));
        r.d_dir_b = sat(rshift_round(g * jy));
        r.d_dir_c = sat(rshift_round(g * jz));
        r.last_result = p.last_point;
        if (p.last_point) set_open = 0;
        return r;
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        case (idx)
            REG_PX:  axis_x = longint'($signed(value));
            REG_PY:  axis_y = longint'($signed(value));
            REG_PZ:  axis_z = longint'($signed(value));
            REG_DA:  dir_a = longint'($signed(value));
            REG_DB:  dir_b = longint'($signed(value));
            REG_DC:  dir_c = longint'($signed(value));
            REG_RAD: radius = longint'(value[30:0]);
            REG_LIM: limit = longint'(value[16:0]);
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z, bit last);
        int gap;
        t_in p;
        gap = no_idle ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            pts.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        p.point_x = x;
        p.point_y = y;
        p.point_z = z;
        p.last_point = last;
        pts.valid <= 1'b1;
        pts.data <= p;
        do @(posedge i_clk); while (!(pts.valid && pts.ready));
        expected_results.push_back(fit_point(p));
        @(negedge i_clk);
    endtask

    task automatic drain();
        pts.valid <= 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_coord(longint center);
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'(center) + $urandom_range(0, 32'h60000) - 32'h30000;
            2: return 32'(center) + $urandom_range(0, 32'h1000) - 32'h800;
            default: return $urandom_range(0, 32'h200000) - 32'h100000;
        endcase
    endfunction

    function automatic logic [31:0] rand_dir();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'h80000000;
            2: return 32'h7fffffff;
            3: return $urandom;
            default: return $urandom_range(0, 32'h40000) - 32'h20000;
        endcase
    endfunction

    task automatic random_config();
        write_reg(REG_PX, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h80000));
        write_reg(REG_PY, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h80000));
        write_reg(REG_PZ, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h80000));
        write_reg(REG_DA, rand_dir());
        write_reg(REG_DB, rand_dir());
        write_reg(REG_DC, rand_dir());
        case ($urandom_range(0, 3))
            0: write_reg(REG_RAD, 32'd0);
            1: write_reg(REG_RAD, 32'h7fffffff);
            2: write_reg(REG_RAD, $urandom);
            default: write_reg(REG_RAD, $urandom_range(0, 32'h80000));
        endcase
        case ($urandom_range(0, 2))
            0: write_reg(REG_LIM, 32'd0);
            1: write_reg(REG_LIM, 32'd65536);
            default: write_reg(REG_LIM, $urandom_range(0, 65536));
        endcase
    endtask

    task automatic send_sets(int count);
        int left;
        bit last;
        left = $urandom_range(1, 12);
        repeat (count) begin
            left--;
            last = (left == 0);
            if ($urandom_range(0, 9) == 0) last = $urandom_range(0, 1);
            send_point(rand_coord(axis_x), rand_coord(axis_y), rand_coord(axis_z), last);
            if (last || left == 0) left = $urandom_range(1, 12);
        end
    endtask

    task automatic test_directed_extremes();
        send_point(32'h00020000, 32'd0, 32'd0, 1'b1);
        send_point(32'd0, 32'h00050000, 32'd0, 1'b0);
        send_point(32'h7fffffff, 32'h80000000, 32'h7fffffff, 1'b0);
        send_point(32'h80000000, 32'h7fffffff, 32'h80000000, 1'b0);
        send_point(32'hffffffff, 32'hffffffff, 32'hffffffff, 1'b1);
        drain();
        write_reg(REG_PX, 32'h80000000);
        write_reg(REG_PY, 32'h7fffffff);
        write_reg(REG_PZ, 32'h00010000);
        write_reg(REG_DA, 32'h80000000);
        write_reg(REG_DB, 32'h7fffffff);
        write_reg(REG_DC, 32'h80000000);
        write_reg(REG_RAD, 32'hffffffff);
        write_reg(REG_LIM, 32'd65536);
        send_point(32'h7fffffff, 32'h80000000, 32'h7fffffff, 1'b0);
        send_point(32'h80000000, 32'h7fffffff, 32'h00010000, 1'b0);
        send_point(32'h00000001, 32'h00000000, 32'h80000000, 1'b1);
        drain();
        // zero direction; points on and off the axis
        write_reg(REG_DA, 32'd0);
        write_reg(REG_DB, 32'd0);
        write_reg(REG_DC, 32'd0);
        write_reg(REG_RAD, 32'd0);
        send_point(32'h80000000, 32'h7fffffff, 32'h00010000, 1'b0);
        send_point(32'h80000100, 32'h7ffffff0, 32'h00010010, 1'b0);
        send_point(32'h12345678, 32'h9abcdef0, 32'h0f0f0f0f, 1'b1);
        drain();
    endtask

    task automatic test_degenerate_branch();
        write_reg(REG_PX, 32'd0);
        write_reg(REG_PY, 32'd0);
        write_reg(REG_PZ, 32'd0);
        write_reg(REG_DA, 32'h00010000);
        write_reg(REG_DB, 32'h00010000);
        write_reg(REG_DC, 32'h00000000);
        write_reg(REG_RAD, 32'h00010000);
        write_reg(REG_LIM, 32'd65536);
        send_point(32'h00030000, 32'h00030000, 32'd0, 1'b0);
        send_point(32'h00030000, 32'h00030000, 32'h00008000, 1'b0);
        send_point(32'h00030001, 32'h00030000, 32'h00010001, 1'b0);
        send_point(32'h7fffffff, 32'h7fffffff, 32'd0, 1'b0);
        drain();
        // direction change with the set still open must not take effect
        write_reg(REG_DB, 32'd0);
        write_reg(REG_LIM, 32'd0);
        send_point(32'h00030000, 32'h00030000, 32'd0, 1'b0);
        send_point(32'hfffd0000, 32'h00020000, 32'h00010000, 1'b1);
        send_point(32'h00030000, 32'h00000000, 32'd0, 1'b1);
        drain();
    endtask

    task automatic test_random_sets();
        repeat (8) begin
            random_config();
            no_idle = ($urandom_range(0, 3) == 0);
            send_sets($urandom_range(170, 230));
            no_idle = 0;
            drain();
        end
    endtask

    task automatic test_backpressure();
        random_config();
        no_idle = 1;
        hold_req = 1;
        send_sets(150);
        no_idle = 0;
        send_sets(40);
        drain();
        send_sets(40);
        drain();
    endtask

    initial begin
        int stall;
        res.ready <= 1'b0;
        @(negedge i_clk);
        while (!i_rst_n) @(negedge i_clk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 17);
            if (hold_req) begin
                res.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 0;
            end
            repeat (stall) begin
                res.ready <= 1'b0;
                @(negedge i_clk);
            end
            res.ready <= 1'b1;
            do @(posedge i_clk); while (!(res.valid && res.ready));
            @(negedge i_clk);
        end
    end

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
        if (exp_v !== got_v) begin
            $error("%s: expected %0d, got %0d", name, $signed(exp_v), $signed(got_v));
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out want;
        t_out got;
        if (i_rst_n && res.valid && res.ready) begin
            got = res.data;
            if (expected_results.size() == 0) begin
                $error("unexpected result word: residual %0d", $signed(got.residual));
                error_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("residual", want.residual, got.residual);
                check_field("d_axis_x", want.d_axis_x, got.d_axis_x);
                check_field("d_axis_y", want.d_axis_y, got.d_axis_y);
                check_field("d_axis_z", want.d_axis_z, got.d_axis_z);
                check_field("d_dir_a", want.d_dir_a, got.d_dir_a);
                check_field("d_dir_b", want.d_dir_b, got.d_dir_b);
                check_field("d_dir_c", want.d_dir_c, got.d_dir_c);
                check_field("last_result", 32'(want.last_result), 32'(got.last_result));
            end
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((pts.valid && pts.ready) || (res.valid && res.ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin
        error_count = 0;
        no_idle = 0;
        hold_req = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        pts.valid = 1'b0;
        pts.data = '0;
        reset_model();
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed_extremes();
        test_degenerate_branch();
        test_random_sets();
        test_backpressure();
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

@@ sim.f @@
hw/rtl/cfrj_pkg.sv
hw/rtl/cfrj_if.sv
hw/rtl/cfrj_isqrt.sv
hw/rtl/cfrj_div.sv
hw/rtl/cylinder_fit_residual_jacobian.sv
tb/cylinder_fit_residual_jacobian_test.sv
